// ===== design/bbtw_pkg.sv =====
// Shared types, constants and the tag block byte table for the bounding-box TIFF tag writer.
package bbtw_pkg;

  localparam logic [31:0] MARKER_OK    = 32'hFFD8FFE1;
  localparam logic [15:0] TAG_BYTES    = 16'd50;
  localparam logic [15:0] REGION_START = 16'd12;
  localparam logic [15:0] LENGTH_BIAS  = 16'd4;
  // Smallest APP1 length that still leaves room for the whole tag block.
  localparam logic [15:0] SEG_MIN      = REGION_START + TAG_BYTES - LENGTH_BIAS;
  localparam logic [15:0] REGION_TRIM  = REGION_START - LENGTH_BIAS;
  localparam logic [5:0]  TAG_LAST     = 6'd49;
  localparam logic [5:0]  DIV_LAST     = 6'd33;

  localparam logic FUNC_BEGIN = 1'b0;

  localparam logic [1:0] CFG_SRC_W = 2'd0;
  localparam logic [1:0] CFG_SRC_H = 2'd1;
  localparam logic [1:0] CFG_VID_W = 2'd2;
  localparam logic [1:0] CFG_VID_H = 2'd3;

  typedef enum logic [1:0] {
    RES_BYTE = 2'd0,
    RES_FILL = 2'd1,
    RES_ERR  = 2'd2
  } res_kind_t;

  typedef enum logic [1:0] {
    CMD_ERR   = 2'd0,
    CMD_HDR   = 2'd1,
    CMD_COORD = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic [15:0] src_w;
    logic [15:0] src_h;
    logic [15:0] vid_w;
    logic [15:0] vid_h;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] coord;
    logic        is_y;
    logic [15:0] offset;
    logic        last;
    logic [15:0] kept;
    logic [15:0] fill_start;
    logic [15:0] fill_len;
  } cmd_t;

  typedef struct packed {
    res_kind_t   kind;
    logic [15:0] byte_offset;
    logic [7:0]  byte_value;
    logic [15:0] fill_length;
    logic        run_end;
    logic        frame_done;
    logic [15:0] used_count;
  } res_t;

  function automatic logic [7:0] tag_byte(input logic [5:0] idx, input logic [15:0] vw,
                                          input logic [15:0] vh, input logic [15:0] kept);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      6'd0, 6'd1: b = 8'h4D;
      6'd3:       b = 8'h2A;
      6'd7:       b = 8'h08;
      6'd9:       b = 8'h03;
      6'd10:      b = 8'h01;
      6'd13:      b = 8'h04;
      6'd17:      b = 8'h01;
      6'd20:      b = vw[15:8];
      6'd21:      b = vw[7:0];
      6'd22:      b = 8'h01;
      6'd23:      b = 8'h01;
      6'd25:      b = 8'h04;
      6'd29:      b = 8'h01;
      6'd32:      b = vh[15:8];
      6'd33:      b = vh[7:0];
      6'd34:      b = 8'h96;
      6'd35:      b = 8'h96;
      6'd37:      b = 8'h03;
      6'd40:      b = kept[15:8];
      6'd41:      b = kept[7:0];
      6'd45:      b = TAG_BYTES[7:0];
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== design/bbtw_fifo.sv =====
// Small register-based first-in first-out queue used between the block's parts.
module bbtw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== design/bbtw_front.sv =====
// Front end: accepts items, tracks frame state, commands begins and in-frame coords.
module bbtw_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic                in_func,
  input  logic [31:0]         in_header_marker,
  input  logic [15:0]         in_segment_length,
  input  logic [15:0]         in_requested_count,
  input  logic [15:0]         in_coord_value,
  output logic                cmd_push,
  output bbtw_pkg::cmd_t      cmd,
  input  logic                cmd_full
);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_COLLECT = 3'b010,
    PH_DONE    = 3'b100
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] kept_r, kept_nxt;
  logic [15:0] idx_r, idx_nxt;
  logic [15:0] fill_start_r, fill_start_nxt;
  logic [15:0] fill_len_r, fill_len_nxt;

  logic        accept, hdr_ok, last;
  logic [15:0] region, max_count, clamped, kept, fill_start, coord_off, idx_inc;

  assign in_full = cmd_full;
  assign accept  = in_push & ~cmd_full;

  always_comb begin
    hdr_ok     = (in_header_marker == bbtw_pkg::MARKER_OK) &&
                 (in_segment_length >= bbtw_pkg::SEG_MIN);
    region     = in_segment_length - bbtw_pkg::REGION_TRIM;
    max_count  = (in_segment_length - bbtw_pkg::SEG_MIN) >> 1;
    clamped    = (in_requested_count > max_count) ? max_count : in_requested_count;
    kept       = {clamped[15:2], 2'b00};
    fill_start = bbtw_pkg::TAG_BYTES + {kept[14:0], 1'b0};
    coord_off  = bbtw_pkg::TAG_BYTES + {idx_r[14:0], 1'b0};
    idx_inc    = idx_r + 16'd1;
    last       = (idx_inc >= kept_r);
  end

  always_comb begin
    phase_nxt      = phase_r;
    kept_nxt       = kept_r;
    idx_nxt        = idx_r;
    fill_start_nxt = fill_start_r;
    fill_len_nxt   = fill_len_r;
    cmd_push       = 1'b0;
    cmd            = '0;
    cmd.kind       = bbtw_pkg::CMD_ERR;
    if (accept) begin
      if (in_func == bbtw_pkg::FUNC_BEGIN) begin
        cmd_push = 1'b1;
        if (!hdr_ok) begin
          phase_nxt = PH_IDLE;
        end else begin
          cmd.kind       = bbtw_pkg::CMD_HDR;
          cmd.kept       = kept;
          cmd.fill_start = fill_start;
          cmd.fill_len   = region - fill_start;
          cmd.last       = (kept == '0);
          kept_nxt       = kept;
          idx_nxt        = '0;
          fill_start_nxt = fill_start;
          fill_len_nxt   = region - fill_start;
          phase_nxt      = (kept == '0) ? PH_DONE : PH_COLLECT;
        end
      end else if (phase_r == PH_COLLECT) begin
        cmd_push       = 1'b1;
        cmd.kind       = bbtw_pkg::CMD_COORD;
        cmd.coord      = in_coord_value;
        cmd.is_y       = idx_r[0];
        cmd.offset     = coord_off;
        cmd.last       = last;
        cmd.kept       = kept_r;
        cmd.fill_start = fill_start_r;
        cmd.fill_len   = fill_len_r;
        idx_nxt        = idx_inc;
        if (last) begin
          phase_nxt = PH_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      kept_r  <= '0;
      idx_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      kept_r  <= kept_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_start_r <= fill_start_nxt;
    fill_len_r   <= fill_len_nxt;
  end

endmodule

// ===== design/bbtw_back.sv =====
// Back end: executes commands, scales coordinates with a serial divider and emits result items.
module bbtw_back (
  input  logic           clk,
  input  logic           rst_n,
  input  bbtw_pkg::cfg_t cfg,
  input  logic           cmd_empty,
  input  bbtw_pkg::cmd_t cmd_head,
  output logic           cmd_pop,
  input  logic           res_full,
  output logic           res_push,
  output bbtw_pkg::res_t res
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_ERR  = 8'b0000_0010,
    S_TAG  = 8'b0000_0100,
    S_MUL  = 8'b0000_1000,
    S_PREP = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_HI   = 8'b0100_0000,
    S_LO   = 8'b1000_0000
  } state_t;

  // The fill run goes out while the pending flag is set; the machine then returns to idle.
  localparam state_t S_FILL_SEL = S_IDLE;

  state_t         state_r, state_nxt;
  logic           fill_pend_r, fill_pend_nxt;
  bbtw_pkg::cmd_t cmd_r, cmd_nxt;
  logic [5:0]     cnt_r, cnt_nxt;
  logic [31:0]    prod_r, prod_nxt;
  logic [33:0]    num_r, num_nxt;
  logic [16:0]    rem_r, rem_nxt;

  logic [15:0] mul, div, scaled;
  logic [17:0] rem_sh, d2;
  logic        ge;

  always_comb begin
    mul    = cmd_r.is_y ? cfg.vid_h : cfg.vid_w;
    div    = cmd_r.is_y ? cfg.src_h : cfg.src_w;
    d2     = {1'b0, div, 1'b0};
    rem_sh = {rem_r, num_r[33]};
    ge     = (rem_sh >= d2);
    // A zero divisor or a quotient past 16 bits saturates.
    scaled = ((div == '0) || (num_r[33:16] != '0)) ? 16'hFFFF : num_r[15:0];
  end

  always_comb begin
    state_nxt     = state_r;
    fill_pend_nxt = fill_pend_r;
    cmd_nxt       = cmd_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    cmd_pop       = 1'b0;
    res_push      = 1'b0;
    res           = '0;
    res.kind      = bbtw_pkg::RES_BYTE;
    if (fill_pend_r) begin
      res.kind        = bbtw_pkg::RES_FILL;
      res.byte_offset = cmd_r.fill_start;
      res.fill_length = cmd_r.fill_len;
      res.run_end     = 1'b1;
      res.frame_done  = 1'b1;
      res.used_count  = cmd_r.kept;
      res_push        = ~res_full;
      if (!res_full) begin
        fill_pend_nxt = 1'b0;
        state_nxt     = S_FILL_SEL;
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (!cmd_empty) begin
            cmd_pop = 1'b1;
            cmd_nxt = cmd_head;
            cnt_nxt = '0;
            unique case (cmd_head.kind)
              bbtw_pkg::CMD_HDR:   state_nxt = S_TAG;
              bbtw_pkg::CMD_COORD: state_nxt = S_MUL;
              default:             state_nxt = S_ERR;
            endcase
          end
        end
        S_ERR: begin
          res.kind    = bbtw_pkg::RES_ERR;
          res.run_end = 1'b1;
          res_push    = ~res_full;
          if (!res_full) begin
            state_nxt = S_IDLE;
          end
        end
        S_TAG: begin
          res.byte_offset = {10'd0, cnt_r};
          res.byte_value  = bbtw_pkg::tag_byte(cnt_r, cfg.vid_w, cfg.vid_h, cmd_r.kept);
          res.run_end     = (cnt_r == bbtw_pkg::TAG_LAST) && !cmd_r.last;
          res_push        = ~res_full;
          if (!res_full) begin
            cnt_nxt = cnt_r + 6'd1;
            if (cnt_r == bbtw_pkg::TAG_LAST) begin
              state_nxt     = S_IDLE;
              fill_pend_nxt = cmd_r.last;
            end
          end
        end
        S_MUL: begin
          prod_nxt  = cmd_r.coord * mul;
          state_nxt = S_PREP;
        end
        S_PREP: begin
          // Round half up: (2*v*mul + div) / (2*div).
          num_nxt   = {1'b0, prod_r, 1'b0} + {18'd0, div};
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
        S_DIV: begin
          rem_nxt = ge ? 17'(rem_sh - d2) : rem_sh[16:0];
          num_nxt = {num_r[32:0], ge};
          cnt_nxt = cnt_r + 6'd1;
          if (cnt_r == bbtw_pkg::DIV_LAST) begin
            state_nxt = S_HI;
          end
        end
        S_HI: begin
          res.byte_offset = cmd_r.offset;
          res.byte_value  = scaled[15:8];
          res_push        = ~res_full;
          if (!res_full) begin
            state_nxt = S_LO;
          end
        end
        S_LO: begin
          res.byte_offset = cmd_r.offset + 16'd1;
          res.byte_value  = scaled[7:0];
          res.run_end     = ~cmd_r.last;
          res_push        = ~res_full;
          if (!res_full) begin
            state_nxt     = S_IDLE;
            fill_pend_nxt = cmd_r.last;
          end
        end
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_pend_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      fill_pend_r <= fill_pend_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    prod_r <= prod_nxt;
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
  end

endmodule

// ===== design/bbox_tiff_tag_writer_core.sv =====
// Top level of the bounding-box TIFF tag writer: configuration, front end, queues and back end.
//
// In the back end a begin item is taken from the command queue, then its 50 tag bytes go out
// at one result item per cycle while the output queue has room, plus the fill run when no
// coordinates are kept; an error gives one error result. A coordinate item is taken, then
// come one multiply, one setup step, 34 steps of the bit-serial divider and two byte results
// (with the fill run on the last one). The serial divider sets the coordinate rate. The front
// end accepts an item per cycle while the command queue has room, so items can be queued while
// the back end works; result items wait in the output queue until popped.
module bbox_tiff_tag_writer_core #(
  parameter int CMD_DEPTH = 4,  // commands queued between front and back end, 2 or more
  parameter int OUT_DEPTH = 2   // result items buffered at the output, 2 or more
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_func,
  input  logic [31:0] in_header_marker,
  input  logic [15:0] in_segment_length,
  input  logic [15:0] in_requested_count,
  input  logic [15:0] in_coord_value,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_kind,
  output logic [15:0] out_byte_offset,
  output logic [7:0]  out_byte_value,
  output logic [15:0] out_fill_length,
  output logic        out_run_end,
  output logic        out_frame_done,
  output logic [15:0] out_used_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  bbtw_pkg::cfg_t cfg_r;
  bbtw_pkg::cmd_t cmd_in, cmd_head;
  bbtw_pkg::res_t res_in, res_head;
  logic           cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic           res_push, res_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_w <= 16'd1;
      cfg_r.src_h <= 16'd1;
      cfg_r.vid_w <= 16'd0;
      cfg_r.vid_h <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bbtw_pkg::CFG_SRC_W: cfg_r.src_w <= cfg_data;
        bbtw_pkg::CFG_SRC_H: cfg_r.src_h <= cfg_data;
        bbtw_pkg::CFG_VID_W: cfg_r.vid_w <= cfg_data;
        bbtw_pkg::CFG_VID_H: cfg_r.vid_h <= cfg_data;
        default: ;
      endcase
    end
  end

  bbtw_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_func            (in_func),
    .in_header_marker   (in_header_marker),
    .in_segment_length  (in_segment_length),
    .in_requested_count (in_requested_count),
    .in_coord_value     (in_coord_value),
    .cmd_push           (cmd_push),
    .cmd                (cmd_in),
    .cmd_full           (cmd_full)
  );

  bbtw_fifo #(
    .WIDTH ($bits(bbtw_pkg::cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_head),
    .empty (cmd_empty)
  );

  bbtw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_empty (cmd_empty),
    .cmd_head  (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  bbtw_fifo #(
    .WIDTH ($bits(bbtw_pkg::res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_head),
    .empty (out_empty)
  );

  assign out_kind        = res_head.kind;
  assign out_byte_offset = res_head.byte_offset;
  assign out_byte_value  = res_head.byte_value;
  assign out_fill_length = res_head.fill_length;
  assign out_run_end     = res_head.run_end;
  assign out_frame_done  = res_head.frame_done;
  assign out_used_count  = res_head.used_count;

  a_cmd_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> !cmd_full)
    else $error("command pushed into a full queue");

  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result item pushed into a full output queue");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind == bbtw_pkg::RES_ERR) |-> (out_run_end && !out_frame_done))
    else $error("error result item without run end or with frame done");

endmodule
